// ----- hw/rtl/block_rms_peak_meter_macros.svh -----
// assertion macros for the rms and peak level meter checker
`ifndef BLOCK_RMS_PEAK_METER_MACROS_SVH
`define BLOCK_RMS_PEAK_METER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RPM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rms peak meter check failed");

// antecedent implies consequent in the next cycle
`define RPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rms peak meter check failed");

`endif

// ----- hw/rtl/rpm_pkg.sv -----
// shared types and constants for the rms and peak level meter
package rpm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_BLOCK   = 4096;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 24;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SUM_W       = 58;
    localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
    localparam int ROOT_W      = SUM_W / 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [IN_W-1:0] sample;
        logic                   last_sample;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_W-1:0] rms_level;
        logic [OUT_W-1:0] peak_level;
    } t_out_beat;

    typedef struct packed {
        logic [SUM_W-1:0]       sum;
        logic [CNT_W-1:0]       count;
        logic [SAMPLE_BITS-1:0] peak;
    } t_blk;

endpackage

// ----- hw/rtl/rpm_front.sv -----
// front end: magnitude, square, accumulate and peak per block
module rpm_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  rpm_pkg::t_in_beat        i_data,
    input  logic [rpm_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                     o_push,
    output rpm_pkg::t_blk            o_blk
);

    localparam int SB = rpm_pkg::SAMPLE_BITS;

    logic                        r_v1, r_last1;
    logic [SB-1:0]               r_mag1;
    logic                        r_v2, r_last2;
    logic [SB-1:0]               r_mag2;
    logic [rpm_pkg::SQ_W-1:0]    r_sq2;
    logic [rpm_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [rpm_pkg::CNT_W-1:0]   r_count, n_count;
    logic [SB-1:0]               r_peak, n_peak;

    logic [SB-1:0]               raw;
    logic [SB-1:0]               mag;
    logic                        accept;
    logic [rpm_pkg::SUM_W:0]     sum_ext;
    logic [rpm_pkg::Q_CNT_W:0]   pending;

    assign raw    = i_data.sample[SB-1:0];
    assign mag    = raw[SB-1] ? (~raw + SB'(1)) : raw;
    assign accept = i_valid && o_ready;

    // reserve queue room for every block end still in flight
    assign pending = (rpm_pkg::Q_CNT_W + 1)'(i_q_count)
                   + (rpm_pkg::Q_CNT_W + 1)'(r_v1 && r_last1)
                   + (rpm_pkg::Q_CNT_W + 1)'(r_v2 && r_last2);
    assign o_ready = pending < (rpm_pkg::Q_CNT_W + 1)'(rpm_pkg::Q_DEPTH);

    assign sum_ext = {1'b0, r_sum} + (rpm_pkg::SUM_W + 1)'(r_sq2);

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_peak  = (r_mag2 > r_peak) ? r_mag2 : r_peak;
        if (r_count < rpm_pkg::CNT_W'(rpm_pkg::MAX_BLOCK)) begin
            n_sum   = sum_ext[rpm_pkg::SUM_W] ? '1 : sum_ext[rpm_pkg::SUM_W-1:0];
            n_count = r_count + rpm_pkg::CNT_W'(1);
        end
    end

    assign o_push      = r_v2 && r_last2;
    assign o_blk.sum   = n_sum;
    assign o_blk.count = n_count;
    assign o_blk.peak  = n_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_sum   <= '0;
            r_count <= '0;
            r_peak  <= '0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            if (r_v2) begin
                if (r_last2) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_peak  <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    r_peak  <= n_peak;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag1  <= mag;
        r_last1 <= i_data.last_sample;
        r_mag2  <= r_mag1;
        r_last2 <= r_last1;
        r_sq2   <= rpm_pkg::SQ_W'(r_mag1) * rpm_pkg::SQ_W'(r_mag1);
    end

endmodule

// ----- hw/rtl/rpm_queue.sv -----
// short queue of finished block totals between front and back
module rpm_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  rpm_pkg::t_blk               i_blk,
    input  logic                        i_pop,
    output logic                        o_valid,
    output rpm_pkg::t_blk               o_blk,
    output logic [rpm_pkg::Q_CNT_W-1:0] o_count
);

    rpm_pkg::t_blk                r_mem [rpm_pkg::Q_DEPTH];
    logic [rpm_pkg::Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [rpm_pkg::Q_CNT_W-1:0]  r_count;
    logic                         do_pop;

    assign o_valid = r_count != '0;
    assign o_blk   = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + rpm_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + rpm_pkg::Q_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + rpm_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - rpm_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_blk;
        end
    end

endmodule

// ----- hw/rtl/rpm_back.sv -----
// back end: serial divide by count, serial square root, result register
module rpm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  rpm_pkg::t_blk     i_blk,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output rpm_pkg::t_out_beat o_data
);

    localparam int SW     = rpm_pkg::SUM_W;
    localparam int CW     = rpm_pkg::CNT_W;
    localparam int RW     = rpm_pkg::ROOT_W;
    localparam int STEP_W = $clog2(SW);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_ROOT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                       r_state;
    logic [STEP_W-1:0]            r_step;
    logic [SW-1:0]                r_num;
    logic [CW-1:0]                r_den;
    logic [CW-1:0]                r_rem;
    logic [RW:0]                  r_srem;
    logic [RW-1:0]                r_root;
    logic [rpm_pkg::SAMPLE_BITS-1:0] r_peak;

    logic [CW:0]                  div_shift;
    logic                         div_ge;
    logic [CW:0]                  div_diff;
    logic [RW+2:0]                root_shift;
    logic [RW+2:0]                root_trial;
    logic                         root_ge;
    logic [RW+2:0]                root_diff;

    assign div_shift  = {r_rem, r_num[SW-1]};
    assign div_ge     = div_shift >= {1'b0, r_den};
    assign div_diff   = div_shift - {1'b0, r_den};

    assign root_shift = {r_srem, r_num[SW-1:SW-2]};
    assign root_trial = {1'b0, r_root, 2'b01};
    assign root_ge    = root_shift >= root_trial;
    assign root_diff  = root_shift - root_trial;

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_state == S_OUT;
    assign o_data.rms_level  = rpm_pkg::OUT_W'(r_root);
    assign o_data.peak_level = rpm_pkg::OUT_W'(r_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_q_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(SW - 1)) begin
                        r_step  <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_ROOT: begin
                    if (r_step == STEP_W'(RW - 1)) begin
                        r_step  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_num  <= i_blk.sum;
                r_den  <= i_blk.count;
                r_peak <= i_blk.peak;
                r_rem  <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
                if (r_step == STEP_W'(SW - 1)) begin
                    // empty block gives zero
                    r_num  <= (r_den == '0) ? '0 : {r_num[SW-2:0], div_ge};
                    r_srem <= '0;
                    r_root <= '0;
                end else begin
                    r_num <= {r_num[SW-2:0], div_ge};
                end
            end
            S_ROOT: begin
                r_num  <= {r_num[SW-3:0], 2'b00};
                r_srem <= root_ge ? root_diff[RW:0] : root_shift[RW:0];
                r_root <= {r_root[RW-2:0], root_ge};
            end
            S_OUT: begin
                r_peak <= r_peak;
            end
            default: begin
                r_peak <= r_peak;
            end
        endcase
    end

endmodule

// ----- hw/rtl/block_rms_peak_meter.sv -----
// top level of the rms and peak level meter
//
// Input channel: one signed sample beat per cycle on i_valid / o_ready, with
// last_sample marking the final beat of a block. Output channel: one beat per
// block on o_valid / i_ready carrying the floor rms and the peak magnitude.
// While o_ready is high the front end takes one sample every cycle:
// magnitude, a registered square and the running sum, count and peak. A
// block end pushes the totals into a four-entry queue. The back end pops
// one block at a time and runs a bit serial divide by the count and then
// a serial square root before it raises o_valid. It pops the next block
// only from idle, after the receiver takes the result, so blocks that end
// while it is busy wait in the queue; o_ready drops only when the queue
// plus the block ends still in the front pipeline would fill it.
// Beyond 4096 samples a block's rms covers the first 4096 only.
// While the receiver stalls the result holds on o_data and the back
// end waits; the front end keeps taking samples until the queue is full.
// Synchronous reset clears the accumulators, the queue and the back end;
// o_ready is high and o_valid low in the first cycle after reset.
module block_rms_peak_meter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rpm_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rpm_pkg::t_out_beat o_data
);

    logic                         q_push;
    rpm_pkg::t_blk                q_in_blk;
    logic                         q_pop;
    logic                         q_valid;
    rpm_pkg::t_blk                q_out_blk;
    logic [rpm_pkg::Q_CNT_W-1:0]  q_count;

    rpm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_blk     (q_in_blk)
    );

    rpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_blk   (q_in_blk),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_blk   (q_out_blk),
        .o_count (q_count)
    );

    rpm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_blk     (q_out_blk),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

// ----- hw/rtl/rpm_checker.sv -----
// port level checks for the rms and peak level meter, bound to the top level
`include "block_rms_peak_meter_macros.svh"

module rpm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_ready,
    input  logic               o_valid,
    input  logic               i_ready,
    input  rpm_pkg::t_out_beat o_data
);

    `RPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `RPM_ASSERT_NEXT(a_reset_state, i_clk, 1'b1, !i_rst_n, !o_valid && o_ready)
    `RPM_ASSERT_NOW(a_rms_le_peak, i_clk, i_rst_n, o_valid, o_data.rms_level <= o_data.peak_level)
    `RPM_ASSERT_NOW(a_peak_range, i_clk, i_rst_n, o_valid,
        o_data.peak_level <= rpm_pkg::OUT_W'(1 << (rpm_pkg::SAMPLE_BITS - 1)))

endmodule

bind block_rms_peak_meter rpm_checker u_rpm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
